// File: rtl/dcm_pkg.sv
// Shared types and constants for the DQCSK chirp mapper.
package dcm_pkg;

    localparam int MaxSubchirpLen = 32;
    localparam int MaxSubchirps   = 4;
    localparam int MaxGapLen      = 32;
    localparam int ChirpDepth     = MaxSubchirpLen * MaxSubchirps;
    localparam int GapDepth       = 2 * MaxGapLen;
    localparam int FifoDepth      = 4;

    localparam logic [1:0] CMD_PHASE = 2'd0;
    localparam logic [1:0] CMD_CHIRP = 2'd1;
    localparam logic [1:0] CMD_GAP1  = 2'd2;
    localparam logic [1:0] CMD_GAP2  = 2'd3;

    localparam logic [1:0] REG_SUB_LEN  = 2'd0;
    localparam logic [1:0] REG_SUB_CNT  = 2'd1;
    localparam logic [1:0] REG_GAP1_LEN = 2'd2;
    localparam logic [1:0] REG_GAP2_LEN = 2'd3;

    // round(2^24 * 8/pi): radians Q4.12 to 2^-16 turn
    localparam logic signed [27:0] ANG_SCALE = 28'sd42722830;

    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026994;
    localparam logic [30:0] SIN_C9 = 31'd172271;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_SIN,
        ST_SINW,
        ST_COS,
        ST_COSW,
        ST_CHIRP,
        ST_GAP
    } t_state;

    typedef enum logic [1:0] {
        TR_IDLE,
        TR_SQ,
        TR_HORNER,
        TR_FIN
    } t_trig_state;

    typedef struct packed {
        logic        start;
        logic [15:0] angle;
    } t_trig_req;

    typedef struct packed {
        logic               done;
        logic signed [15:0] value;
    } t_trig_rsp;

    // Horner coefficients after the C9 seed, in step order
    function automatic logic [30:0] horner_coef(input logic [1:0] k);
        case (k)
            2'd0:    horner_coef = SIN_C7;
            2'd1:    horner_coef = SIN_C5;
            2'd2:    horner_coef = SIN_C3;
            default: horner_coef = SIN_C1;
        endcase
    endfunction

endpackage

// File: rtl/dcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dcm_trig.sv
// Iterative sine unit: one shared multiplier steps a degree-9 Horner polynomial.
module dcm_trig (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcm_pkg::t_trig_req i_req,
    output dcm_pkg::t_trig_rsp o_rsp
);
    import dcm_pkg::*;

    t_trig_state r_state, n_state;
    logic [14:0] r_r, n_r;
    logic [14:0] r_z2, n_z2;
    logic [30:0] r_t, n_t;
    logic [1:0]  r_k, n_k;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic signed [15:0] r_val, n_val;

    logic [30:0] mul_a;
    logic [14:0] mul_b;
    logic [45:0] prod;
    logic [46:0] fin_sum;
    logic [17:0] fin_s;
    logic [14:0] mag;

    assign prod    = {15'd0, mul_a} * {31'd0, mul_b};
    assign fin_sum = {1'b0, prod} + 47'd268435456;
    assign fin_s   = fin_sum[46:29];
    assign mag     = (fin_s > 18'd32767) ? 15'h7FFF : fin_s[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_r   <= n_r;
        r_z2  <= n_z2;
        r_t   <= n_t;
        r_k   <= n_k;
        r_neg <= n_neg;
        r_val <= n_val;
    end

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_z2    = r_z2;
        n_t     = r_t;
        n_k     = r_k;
        n_neg   = r_neg;
        n_val   = r_val;
        n_done  = 1'b0;
        mul_a   = r_t;
        mul_b   = r_z2;
        case (r_state)
            TR_IDLE: begin
                if (i_req.start) begin
                    // fold the quadrant onto the first quarter wave
                    n_r     = i_req.angle[14] ? (15'd16384 - {1'b0, i_req.angle[13:0]})
                                              : {1'b0, i_req.angle[13:0]};
                    n_neg   = i_req.angle[15];
                    n_state = TR_SQ;
                end
            end
            TR_SQ: begin
                mul_a   = {16'd0, r_r};
                mul_b   = r_r;
                n_z2    = prod[28:14];
                n_t     = SIN_C9;
                n_k     = 2'd0;
                n_state = TR_HORNER;
            end
            TR_HORNER: begin
                mul_a = r_t;
                mul_b = r_z2;
                n_t   = horner_coef(r_k) - prod[44:14];
                n_k   = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = TR_FIN;
                end
            end
            TR_FIN: begin
                mul_a   = r_t;
                mul_b   = r_r;
                n_val   = r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                n_done  = 1'b1;
                n_state = TR_IDLE;
            end
            default: n_state = TR_IDLE;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;

endmodule

// File: rtl/dcm_chirp_mapper_core.sv
// Top level of the DQCSK chirp mapper: sequencer, rotation pipeline, output queue.
//
// Input stream: tuser carries the command, tdata the payload. Write beats store one
// table entry and produce nothing; ready stays high for them.
// A phase beat drops ready while the item runs: the angle product, then the shared
// sine unit (sine, then cosine), then one table read per cycle, unless the output
// queue holds it back, for subchirp_length samples plus, after the last subchirp
// of a chirp, the gap length. Samples leave through a rotation pipeline (read,
// multiply, round) into a 4-entry output queue. When the receiver stalls, table
// reads pause once the queue and the pipeline together hold 4 samples; nothing
// is dropped. The item's final sample carries tlast. The configuration channel
// is always ready.
// Reset (synchronous, active low) empties the queue, returns to idle, clears
// the subchirp counter and chirp parity and loads the register defaults.
// Table contents are undefined until written.
module dqcsk_chirp_mapper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] phase_angle, [22:16] table_index, [38:23] entry_real,
    // [54:39] entry_imag, [55] zero
    input  logic [55:0] i_s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] sample_real, [31:16] sample_imag
    output logic [31:0] o_m_axis_tdata,
    // [0] from_gap
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [5:0]  i_cfg_data
);
    import dcm_pkg::*;

    localparam int CAW = $clog2(ChirpDepth);
    localparam int GAW = $clog2(GapDepth);
    localparam int FAW = $clog2(FifoDepth);

    // configuration
    logic [5:0] r_sub_len, r_gap1_len, r_gap2_len;
    logic [2:0] r_sub_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_len  <= 6'(MaxSubchirpLen);
            r_sub_cnt  <= 3'(MaxSubchirps);
            r_gap1_len <= 6'd0;
            r_gap2_len <= 6'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_SUB_LEN:  r_sub_len  <= i_cfg_data;
                REG_SUB_CNT:  r_sub_cnt  <= i_cfg_data[2:0];
                REG_GAP1_LEN: r_gap1_len <= i_cfg_data;
                REG_GAP2_LEN: r_gap2_len <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    logic [5:0] len_eff, glen1_eff, glen2_eff;
    logic [2:0] cnt_eff;
    assign len_eff   = (r_sub_len == 6'd0) ? 6'd1 :
                       (r_sub_len > 6'(MaxSubchirpLen)) ? 6'(MaxSubchirpLen) : r_sub_len;
    assign cnt_eff   = (r_sub_cnt == 3'd0) ? 3'd1 :
                       (r_sub_cnt > 3'(MaxSubchirps)) ? 3'(MaxSubchirps) : r_sub_cnt;
    assign glen1_eff = (r_gap1_len > 6'(MaxGapLen)) ? 6'(MaxGapLen) : r_gap1_len;
    assign glen2_eff = (r_gap2_len > 6'(MaxGapLen)) ? 6'(MaxGapLen) : r_gap2_len;

    // input fields
    logic [1:0]  in_cmd;
    logic [15:0] in_phase;
    logic [6:0]  in_idx;
    logic [31:0] in_entry;
    logic        in_accept;
    assign in_cmd    = i_s_axis_tuser;
    assign in_phase  = i_s_axis_tdata[15:0];
    assign in_idx    = i_s_axis_tdata[22:16];
    assign in_entry  = i_s_axis_tdata[54:23];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // sequencer state
    t_state r_state, n_state;
    logic [1:0]  r_sub_idx, n_sub_idx;
    logic        r_odd, n_odd;
    logic [15:0] r_phase, n_phase;
    logic [15:0] r_ang, n_ang;
    logic signed [15:0] r_sin, n_sin, r_cos, n_cos;
    logic [CAW-1:0] r_base, n_base;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_end, n_end;
    logic        r_gsel, n_gsel;
    logic [5:0]  r_glen, n_glen;

    logic signed [43:0] ang_prod;
    logic signed [43:0] ang_sum;
    assign ang_prod = 44'($signed(r_phase) * ANG_SCALE);
    assign ang_sum  = ang_prod + 44'sd8388608;

    t_trig_req trig_req;
    t_trig_rsp trig_rsp;

    dcm_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (trig_req),
        .o_rsp   (trig_rsp)
    );

    // pipeline / queue bookkeeping
    logic           r_v1, r_v2;
    logic           r_g1, r_l1, r_g2, r_l2;
    logic [FAW:0]   r_count;
    logic           issue_ok, issue, issue_gap, issue_last;
    logic [2:0]     in_flight;
    assign in_flight = {2'd0, r_v1} + {2'd0, r_v2};
    assign issue_ok  = ({1'b0, r_count} + {1'b0, in_flight}) < (FAW+2)'(FifoDepth);

    logic [1:0] idx_eff;
    logic [7:0] base_full;
    assign idx_eff   = ({1'b0, r_sub_idx} >= cnt_eff) ? 2'd0 : r_sub_idx;
    assign base_full = {6'd0, idx_eff} * {2'd0, len_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sub_idx <= 2'd0;
            r_odd     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sub_idx <= n_sub_idx;
            r_odd     <= n_odd;
        end
        r_phase <= n_phase;
        r_ang   <= n_ang;
        r_sin   <= n_sin;
        r_cos   <= n_cos;
        r_base  <= n_base;
        r_cnt   <= n_cnt;
        r_end   <= n_end;
        r_gsel  <= n_gsel;
        r_glen  <= n_glen;
    end

    always_comb begin
        n_state    = r_state;
        n_sub_idx  = r_sub_idx;
        n_odd      = r_odd;
        n_phase    = r_phase;
        n_ang      = r_ang;
        n_sin      = r_sin;
        n_cos      = r_cos;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_end      = r_end;
        n_gsel     = r_gsel;
        n_glen     = r_glen;
        trig_req   = '0;
        issue      = 1'b0;
        issue_gap  = 1'b0;
        issue_last = 1'b0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid && in_cmd == CMD_PHASE) begin
                    n_phase = in_phase;
                    n_base  = base_full[CAW-1:0];
                    n_cnt   = 6'd0;
                    n_gsel  = r_odd;
                    n_glen  = r_odd ? glen2_eff : glen1_eff;
                    if ({1'b0, idx_eff} + 3'd1 >= cnt_eff) begin
                        n_end     = 1'b1;
                        n_sub_idx = 2'd0;
                        n_odd     = ~r_odd;
                    end else begin
                        n_end     = 1'b0;
                        n_sub_idx = idx_eff + 2'd1;
                    end
                    n_state = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                n_ang   = ang_sum[39:24];
                n_state = ST_SIN;
            end
            ST_SIN: begin
                trig_req.start = 1'b1;
                trig_req.angle = r_ang;
                n_state        = ST_SINW;
            end
            ST_SINW: begin
                if (trig_rsp.done) begin
                    n_sin   = trig_rsp.value;
                    n_state = ST_COS;
                end
            end
            ST_COS: begin
                trig_req.start = 1'b1;
                trig_req.angle = r_ang + 16'd16384;
                n_state        = ST_COSW;
            end
            ST_COSW: begin
                if (trig_rsp.done) begin
                    n_cos   = trig_rsp.value;
                    n_state = ST_CHIRP;
                end
            end
            ST_CHIRP: begin
                if (issue_ok) begin
                    issue = 1'b1;
                    if (r_cnt == len_eff - 6'd1) begin
                        n_cnt = 6'd0;
                        if (r_end && r_glen != 6'd0) begin
                            n_state = ST_GAP;
                        end else begin
                            issue_last = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            ST_GAP: begin
                if (issue_ok) begin
                    issue     = 1'b1;
                    issue_gap = 1'b1;
                    if (r_cnt == r_glen - 6'd1) begin
                        issue_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // tables
    logic           chirp_we, gap_we;
    logic [31:0]    chirp_q, gap_q;
    logic [CAW-1:0] chirp_raddr;
    logic [GAW-1:0] gap_raddr, gap_waddr;

    assign chirp_we    = in_accept && in_cmd == CMD_CHIRP;
    assign gap_we      = in_accept && (in_cmd == CMD_GAP1 || in_cmd == CMD_GAP2)
                         && in_idx[6:GAW-1] == '0;
    assign gap_waddr   = {in_cmd == CMD_GAP2, in_idx[GAW-2:0]};
    assign chirp_raddr = r_base + CAW'(r_cnt);
    assign gap_raddr   = {r_gsel, r_cnt[GAW-2:0]};

    dcm_ram #(.WIDTH(32), .DEPTH(ChirpDepth)) u_chirp_ram (
        .i_clk   (i_clk),
        .i_we    (chirp_we),
        .i_waddr (in_idx[CAW-1:0]),
        .i_wdata (in_entry),
        .i_raddr (chirp_raddr),
        .o_rdata (chirp_q)
    );

    dcm_ram #(.WIDTH(32), .DEPTH(GapDepth)) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (gap_we),
        .i_waddr (gap_waddr),
        .i_wdata (in_entry),
        .i_raddr (gap_raddr),
        .o_rdata (gap_q)
    );

    // rotation pipeline
    logic [31:0]        e1;
    logic signed [15:0] er, ei;
    logic signed [31:0] r_p_rc, r_p_is, r_p_rs, r_p_ic;
    logic [31:0]        r_raw;
    assign e1 = r_g1 ? gap_q : chirp_q;
    assign er = $signed(e1[15:0]);
    assign ei = $signed(e1[31:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
        r_g1   <= issue_gap;
        r_l1   <= issue_last;
        r_g2   <= r_g1;
        r_l2   <= r_l1;
        r_raw  <= e1;
        r_p_rc <= er * r_cos;
        r_p_is <= ei * r_sin;
        r_p_rs <= er * r_sin;
        r_p_ic <= ei * r_cos;
    end

    function automatic logic [15:0] round_sat(input logic signed [32:0] x);
        logic signed [33:0] y;
        logic signed [18:0] q;
        y = {x[32], x} + 34'sd16384;
        q = y[33:15];
        if (q > 19'sd32767) round_sat = 16'h7FFF;
        else if (q < -19'sd32768) round_sat = 16'h8000;
        else round_sat = q[15:0];
    endfunction

    logic [15:0] rot_re, rot_im;
    logic [31:0] push_data;
    assign rot_re    = round_sat(33'(r_p_rc) - 33'(r_p_is));
    assign rot_im    = round_sat(33'(r_p_rs) + 33'(r_p_ic));
    assign push_data = r_g2 ? r_raw : {rot_im, rot_re};

    // output queue
    logic [31:0]    r_fdata [FifoDepth];
    logic [FifoDepth-1:0] r_fgap, r_flast;
    logic [FAW-1:0] r_wr, r_rd;
    logic           pop;
    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (r_v2) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (FAW+1)'(r_v2) - (FAW+1)'(pop);
        end
        if (r_v2) begin
            r_fdata[r_wr] <= push_data;
            r_fgap[r_wr]  <= r_g2;
            r_flast[r_wr] <= r_l2;
        end
    end

    assign o_m_axis_tvalid = r_count != '0;
    assign o_m_axis_tdata  = r_fdata[r_rd];
    assign o_m_axis_tuser  = r_fgap[r_rd];
    assign o_m_axis_tlast  = r_flast[r_rd];

endmodule

// File: rtl/dcm_checker.sv
// Port-level checks on the chirp mapper, bound to the top level.
module dcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import dcm_pkg::*;

    // queue is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // a phase beat busies the input side
    a_phase_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == CMD_PHASE
        |=> !o_s_axis_tready)
        else $error("input ready right after a phase beat");

    // angle and sine/cosine work keep the input busy after a phase beat
    a_busy_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == CMD_PHASE
        |=> !o_s_axis_tready [*17])
        else $error("input ready before the sine work finished");

    // stalled output beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output beat changed");

endmodule

bind dqcsk_chirp_mapper_core dcm_checker u_dcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: sim/tb_dqcsk_chirp_mapper_core.sv
// Self-checking testbench for the DQCSK chirp mapper: random stream traffic with a predictor.
`timescale 1ns / 1ps

module tb_dqcsk_chirp_mapper_core;
    import dcm_pkg::*;

    localparam int WatchLimit = 3000;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] phase;
        logic [6:0]  idx;
        logic [15:0] er;
        logic [15:0] ei;
    } t_beat;

    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic        gap;
        logic        last;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [55:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [5:0]  cfg_data = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    dqcsk_chirp_mapper_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_beat   pending_beats[$];
    t_sample expected_samples[$];
    int      error_count = 0;
    int      sample_count = 0;
    bit      calm = 1'b0;

    // predictor state
    logic [31:0] chirp_mem[ChirpDepth];
    logic [31:0] gap1_mem[MaxGapLen];
    logic [31:0] gap2_mem[MaxGapLen];
    int unsigned sub_idx = 0;
    bit          odd_chirp = 1'b0;
    int unsigned reg_len = 32, reg_cnt = 4, reg_g1 = 0, reg_g2 = 0;

    function automatic int quarter_sine(int unsigned r);
        longint unsigned z, z2, t, s;
        z  = r;
        z2 = (z * z) >> 14;
        t  = SIN_C9;
        t  = SIN_C7 - ((t * z2) >> 14);
        t  = SIN_C5 - ((t * z2) >> 14);
        t  = SIN_C3 - ((t * z2) >> 14);
        t  = SIN_C1 - ((t * z2) >> 14);
        s  = (t * z + (64'd1 << 28)) >> 29;
        if (s > 32767) s = 32767;
        return int'(s);
    endfunction

    function automatic int turn_sine(logic [15:0] a);
        int unsigned r;
        r = a[13:0];
        case (a[15:14])
            2'd0:    return quarter_sine(r);
            2'd1:    return quarter_sine(16384 - r);
            2'd2:    return -quarter_sine(r);
            default: return -quarter_sine(16384 - r);
        endcase
    endfunction

    function automatic logic [15:0] round_sat_q15(longint x);
        longint v;
        v = ((x + (64'sd1 <<< 40) + (64'sd1 <<< 14)) >>> 15) - (64'sd1 <<< 25);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic predict_beat(t_beat b);
        int unsigned len, cnt, glen, base;
        logic [15:0] a;
        longint p, er, ei;
        int c, s;
        logic [31:0] e;
        t_sample smp;
        if (b.cmd != CMD_PHASE) begin
            if (b.cmd == CMD_CHIRP) chirp_mem[b.idx] = {b.ei, b.er};
            else if (b.idx < MaxGapLen) begin
                if (b.cmd == CMD_GAP1) gap1_mem[b.idx[4:0]] = {b.ei, b.er};
                else gap2_mem[b.idx[4:0]] = {b.ei, b.er};
            end
            return;
        end
        len = (reg_len < 1) ? 1 : (reg_len > MaxSubchirpLen) ? MaxSubchirpLen : reg_len;
        cnt = (reg_cnt < 1) ? 1 : (reg_cnt > MaxSubchirps) ? MaxSubchirps : reg_cnt;
        if (sub_idx >= cnt) sub_idx = 0;
        p = longint'($signed(b.phase)) * 42722830;
        p = (p + (64'sd1 <<< 44) + (64'sd1 <<< 23)) >>> 24;
        a = p[15:0];
        s = turn_sine(a);
        c = turn_sine(a + 16'd16384);
        base = sub_idx * len;
        for (int i = 0; i < len; i++) begin
            e  = chirp_mem[(base + i) % ChirpDepth];
            er = longint'($signed(e[15:0]));
            ei = longint'($signed(e[31:16]));
            smp.re   = round_sat_q15(er * c - ei * s);
            smp.im   = round_sat_q15(er * s + ei * c);
            smp.gap  = 1'b0;
            smp.last = 1'b0;
            expected_samples.push_back(smp);
        end
        sub_idx++;
        if (sub_idx >= cnt) begin
            sub_idx = 0;
            glen = odd_chirp ? reg_g2 : reg_g1;
            if (glen > MaxGapLen) glen = MaxGapLen;
            for (int i = 0; i < glen; i++) begin
                e = odd_chirp ? gap2_mem[i] : gap1_mem[i];
                smp.re = e[15:0];
                smp.im = e[31:16];
                smp.gap = 1'b1;
                smp.last = 1'b0;
                expected_samples.push_back(smp);
            end
            odd_chirp = ~odd_chirp;
        end
        expected_samples[$].last = 1'b1;
    endtask

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on sample %0d: %s got %h expected %h", sample_count, what, got, want);
        error_count++;
    endtask

    // driver
    int send_wait = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                predict_beat('{s_user, s_data[15:0], s_data[22:16], s_data[38:23],
                               s_data[54:39]});
            end
            if (!s_valid || o_s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    t_beat b;
                    b = pending_beats.pop_front();
                    s_valid <= 1'b1;
                    s_user  <= b.cmd;
                    s_data  <= {1'b0, b.ei, b.er, b.idx, b.phase};
                    send_wait <= draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor; one long hold-off partway through fills the block up
    int  hold_cnt = 0;
    int  press_cnt = 0;
    int  recv_wait = 0;
    bit  pressed = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected", o_m_axis_tdata, '0);
                end else begin
                    t_sample w;
                    w = expected_samples.pop_front();
                    if (o_m_axis_tdata[15:0] !== w.re)
                        report_mismatch("real", o_m_axis_tdata[15:0], w.re);
                    if (o_m_axis_tdata[31:16] !== w.im)
                        report_mismatch("imag", o_m_axis_tdata[31:16], w.im);
                    if (o_m_axis_tuser !== w.gap)
                        report_mismatch("from_gap", o_m_axis_tuser, w.gap);
                    if (o_m_axis_tlast !== w.last)
                        report_mismatch("last", o_m_axis_tlast, w.last);
                end
                sample_count <= sample_count + 1;
            end
            if (o_m_axis_tvalid && m_ready && sample_count == 150 && !pressed) begin
                pressed <= 1'b1;
                press_cnt <= 400;
                m_ready <= 1'b0;
            end else if (press_cnt > 0) begin
                press_cnt <= press_cnt - 1;
                m_ready <= (press_cnt == 1);
            end else if (o_m_axis_tvalid && m_ready) begin
                recv_wait = draw_wait();
                hold_cnt <= recv_wait;
                m_ready <= (recv_wait == 0);
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= (hold_cnt == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on beats of any channel; also switches idling on and off in stretches
    int idle_cycles = 0;
    int cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 700 == 699) calm <= ~calm;
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
                || (cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_beat mk_beat(logic [1:0] cmd, logic [15:0] ph, logic [6:0] idx,
                                      logic [15:0] er, logic [15:0] ei);
        t_beat b;
        b.cmd = cmd; b.phase = ph; b.idx = idx; b.er = er; b.ei = ei;
        return b;
    endfunction

    function automatic t_beat rand_beat();
        logic [1:0] cmd;
        cmd = ($urandom_range(0, 9) < 6) ? CMD_PHASE : 2'($urandom_range(1, 3));
        return mk_beat(cmd, 16'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    task automatic write_reg(logic [1:0] addr, logic [5:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (addr)
            REG_SUB_LEN:  reg_len = data;
            REG_SUB_CNT:  reg_cnt = data[2:0];
            REG_GAP1_LEN: reg_g1  = data;
            default:      reg_g2  = data;
        endcase
    endtask

    task automatic drain();
        wait (pending_beats.size() == 0 && !s_valid && expected_samples.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_all(logic [5:0] len, logic [5:0] cnt, logic [5:0] g1, logic [5:0] g2);
        drain();
        write_reg(REG_SUB_LEN, len);
        write_reg(REG_SUB_CNT, cnt);
        write_reg(REG_GAP1_LEN, g1);
        write_reg(REG_GAP2_LEN, g2);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every table entry is loaded before any read
        for (int i = 0; i < ChirpDepth; i++)
            pending_beats.push_back(mk_beat(CMD_CHIRP, '0, 7'(i), 16'($urandom), 16'($urandom)));
        for (int i = 0; i < MaxGapLen; i++) begin
            pending_beats.push_back(mk_beat(CMD_GAP1, '0, 7'(i), 16'($urandom), 16'($urandom)));
            pending_beats.push_back(mk_beat(CMD_GAP2, '0, 7'(i), 16'($urandom), 16'($urandom)));
        end
        // full-scale entries to force saturation; out-of-range gap indices are ignored
        pending_beats.push_back(mk_beat(CMD_CHIRP, '0, 7'd0, 16'h8000, 16'h8000));
        pending_beats.push_back(mk_beat(CMD_CHIRP, '0, 7'd1, 16'h7FFF, 16'h7FFF));
        pending_beats.push_back(mk_beat(CMD_GAP1, '0, 7'd127, 16'h1234, 16'h5678));
        pending_beats.push_back(mk_beat(CMD_GAP2, '0, 7'd32, 16'h1234, 16'h5678));

        // reset defaults: 32 samples, 4 subchirps, no gaps
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'hF36F, '0, '0, '0)); // -pi/4
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'h0000, '0, '0, '0));
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'h7FFF, '0, '0, '0));
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'h8000, '0, '0, '0));
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'h0C91, '0, '0, '0)); // pi/4
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'h3244, '0, '0, '0)); // pi
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'h1922, '0, '0, '0)); // pi/2
        pending_beats.push_back(mk_beat(CMD_PHASE, 16'hCDBC, '0, '0, '0)); // -pi

        // shortest subchirp, single subchirp, longest gaps
        set_all(6'd1, 6'd1, 6'd32, 6'd32);
        for (int i = 0; i < 15; i++) pending_beats.push_back(rand_beat());

        // mid settings, zero-length second gap
        set_all(6'd5, 6'd3, 6'd7, 6'd0);
        for (int i = 0; i < 20; i++) pending_beats.push_back(rand_beat());

        // zero length and count act as one, oversize gaps clamp
        set_all(6'd0, 6'd0, 6'd40, 6'd63);
        for (int i = 0; i < 15; i++) pending_beats.push_back(rand_beat());

        // oversize length and count clamp to the maximum
        set_all(6'd63, 6'd7, 6'd1, 6'd3);
        for (int i = 0; i < 15; i++) pending_beats.push_back(rand_beat());

        // count shrinks below a running subchirp index
        drain();
        write_reg(REG_SUB_CNT, 6'd2);
        for (int i = 0; i < 15; i++) pending_beats.push_back(rand_beat());

        for (int k = 0; k < 3; k++) begin
            set_all(6'($urandom_range(1, 8)), 6'($urandom_range(1, 4)),
                    6'($urandom_range(0, 8)), 6'($urandom_range(0, 8)));
            for (int i = 0; i < 8; i++) pending_beats.push_back(rand_beat());
        end

        drain();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/dcm_pkg.sv
rtl/dcm_ram.sv
rtl/dcm_trig.sv
rtl/dcm_chirp_mapper_core.sv
rtl/dcm_checker.sv
sim/tb_dqcsk_chirp_mapper_core.sv
